### design/sck_pkg.sv
package sck_pkg;

    localparam int IN_W    = 24;
    localparam int OUT_W   = 48;
    localparam int Q_FRAC  = 30;
    localparam int Q_W     = 31;
    localparam int POLY_W  = 31;
    localparam int NUM_W   = 61;
    localparam int H3_W    = 72;

    localparam logic [POLY_W-1:0] INV_PI_Q32 = 31'd1367130551;

    localparam logic [1:0] REGION_INNER = 2'd0;
    localparam logic [1:0] REGION_OUTER = 2'd1;
    localparam logic [1:0] REGION_NONE  = 2'd2;

    typedef struct packed {
        logic [IN_W-1:0] distance;
        logic [IN_W-1:0] smoothing_length;
    } sck_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] kernel_value;
        logic [1:0]       region;
        logic             saturated;
        logic             bad_length;
    } sck_out_t;

    typedef struct packed {
        logic [1:0] region;
        logic       bad;
    } sck_side_t;

    typedef struct packed {
        logic [IN_W-1:0] h;
        sck_side_t       info;
    } sck_qside_t;

    typedef struct packed {
        logic      sat;
        sck_side_t info;
    } sck_tail_t;

endpackage

### design/sph_cubic_spline_kernel.sv
// path to done: input reg, r/h divider, poly stages a-d, scale reg, h^3 divider, result reg
// throughput: one item per cycle; busy is always low
// the quotient r/h takes 8 stages of up to 4 bits each, the final divide by h^3 takes 48 stages
// reset: rst_n async active low clears all valid bits and done; data is not reset
// the receiver cannot stall; each result shows for exactly one cycle
module sph_cubic_spline_kernel import sck_pkg::*; #(
    parameter int IN_FRAC_BITS  = 20,
    parameter int OUT_FRAC_BITS = 24
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sck_in_t  request,
    output logic     done,
    output sck_out_t result
);

    localparam int K    = 3 * IN_FRAC_BITS + OUT_FRAC_BITS - 62;
    localparam int KPOS = (K > 0) ? K : 0;
    localparam int KNEG = (K < 0) ? -K : 0;
    localparam int DW   = NUM_W + KPOS;
    localparam int HW   = DW - OUT_W;
    localparam int CW   = (HW > H3_W) ? HW : H3_W;

    assign busy = 1'b0;

    // input register
    logic            in_valid_reg;
    logic [IN_W-1:0] r_reg;
    logic [IN_W-1:0] h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= request.distance;
        h_reg <= request.smoothing_length;
    end

    sck_qside_t qside;

    always_comb
    begin
        qside.h        = h_reg;
        qside.info.bad = (h_reg == '0);
        priority if (h_reg == '0)
        begin
            qside.info.region = REGION_NONE;
        end
        else if (r_reg < h_reg)
        begin
            qside.info.region = REGION_INNER;
        end
        else if ({1'b0, r_reg} < {h_reg, 1'b0})
        begin
            qside.info.region = REGION_OUTER;
        end
        else
        begin
            qside.info.region = REGION_NONE;
        end
    end

    // q = r * 2^30 / h
    logic             q_valid;
    logic [Q_W-1:0]   q_val;
    sck_qside_t       q_side;

    sck_div_pipe #(
        .DEN_W  (IN_W),
        .QUO_W  (Q_W),
        .STEPS  (4),
        .SIDE_W ($bits(sck_qside_t))
    ) u_qdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_rem    ({1'b0, r_reg[IN_W-1:1]}),
        .in_low    ({r_reg[0], {Q_FRAC{1'b0}}}),
        .in_den    (h_reg),
        .in_side   (qside),
        .out_valid (q_valid),
        .out_quo   (q_val),
        .out_side  (q_side)
    );

    logic             p_valid;
    logic [NUM_W-1:0] p_num;
    logic [H3_W-1:0]  p_den;
    sck_side_t        p_side;

    sck_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .q         (q_val),
        .h         (q_side.h),
        .in_side   (q_side.info),
        .out_valid (p_valid),
        .num       (p_num),
        .den       (p_den),
        .out_side  (p_side)
    );

    // scale the numerator, check overflow, seed the final divide
    logic             e_valid_reg;
    logic [H3_W-1:0]  e_rem_reg;
    logic [OUT_W-1:0] e_low_reg;
    logic [H3_W-1:0]  e_den_reg;
    sck_tail_t        e_tail_reg;
    logic [DW-1:0]    n_ext;
    logic [DW-1:0]    d_full;
    logic [HW-1:0]    d_hi;
    sck_tail_t        e_tail_next;

    assign n_ext  = DW'(p_num);
    assign d_full = (n_ext << KPOS) >> KNEG;
    assign d_hi   = d_full[DW-1:OUT_W];

    always_comb
    begin
        e_tail_next.info = p_side;
        e_tail_next.sat  = (CW'(d_hi) >= CW'(p_den));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= p_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        e_rem_reg  <= H3_W'(d_hi);
        e_low_reg  <= d_full[OUT_W-1:0];
        e_den_reg  <= p_den;
        e_tail_reg <= e_tail_next;
    end

    logic             w_valid;
    logic [OUT_W-1:0] w_quo;
    sck_tail_t        w_tail;

    sck_div_pipe #(
        .DEN_W  (H3_W),
        .QUO_W  (OUT_W),
        .STEPS  (1),
        .SIDE_W ($bits(sck_tail_t))
    ) u_wdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_valid_reg),
        .in_rem    (e_rem_reg),
        .in_low    (e_low_reg),
        .in_den    (e_den_reg),
        .in_side   (e_tail_reg),
        .out_valid (w_valid),
        .out_quo   (w_quo),
        .out_side  (w_tail)
    );

    // result register
    logic     done_reg;
    sck_out_t result_reg;
    sck_out_t result_next;

    always_comb
    begin
        result_next.region     = w_tail.info.region;
        result_next.bad_length = w_tail.info.bad;
        priority if (w_tail.info.region == REGION_NONE)
        begin
            result_next.kernel_value = '0;
            result_next.saturated    = 1'b0;
        end
        else if (w_tail.sat)
        begin
            result_next.kernel_value = '1;
            result_next.saturated    = 1'b1;
        end
        else
        begin
            result_next.kernel_value = w_quo;
            result_next.saturated    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= w_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### design/sck_div_pipe.sv
module sck_div_pipe #(
    parameter int DEN_W  = 24,
    parameter int QUO_W  = 31,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [QUO_W-1:0]  in_low,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int NST = (QUO_W + STEPS - 1) / STEPS;

    logic              valid_reg [NST];
    logic [DEN_W-1:0]  rem_reg   [NST];
    logic [QUO_W-1:0]  low_reg   [NST];
    logic [DEN_W-1:0]  den_reg   [NST];
    logic [SIDE_W-1:0] side_reg  [NST];
    logic [DEN_W-1:0]  rem_next  [NST];
    logic [QUO_W-1:0]  low_next  [NST];

    logic              src_valid [NST];
    logic [DEN_W-1:0]  src_rem   [NST];
    logic [QUO_W-1:0]  src_low   [NST];
    logic [DEN_W-1:0]  src_den   [NST];
    logic [SIDE_W-1:0] src_side  [NST];

    genvar g;
    for (g = 0; g < NST; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            assign src_valid[g] = in_valid;
            assign src_rem[g]   = in_rem;
            assign src_low[g]   = in_low;
            assign src_den[g]   = in_den;
            assign src_side[g]  = in_side;
        end
        else
        begin : g_rest
            assign src_valid[g] = valid_reg[g-1];
            assign src_rem[g]   = rem_reg[g-1];
            assign src_low[g]   = low_reg[g-1];
            assign src_den[g]   = den_reg[g-1];
            assign src_side[g]  = side_reg[g-1];
        end

        always_comb
        begin
            logic [DEN_W-1:0] rem_v;
            logic [QUO_W-1:0] low_v;
            logic [DEN_W:0]   trial;
            rem_v = src_rem[g];
            low_v = src_low[g];
            trial = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                if (g * STEPS + j < QUO_W)
                begin
                    trial = {rem_v, low_v[QUO_W-1]};
                    if (trial >= {1'b0, src_den[g]})
                    begin
                        trial = trial - {1'b0, src_den[g]};
                        low_v = {low_v[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        low_v = {low_v[QUO_W-2:0], 1'b0};
                    end
                    rem_v = trial[DEN_W-1:0];
                end
            end
            rem_next[g] = rem_v;
            low_next[g] = low_v;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= src_valid[g];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next[g];
            low_reg[g]  <= low_next[g];
            den_reg[g]  <= src_den[g];
            side_reg[g] <= src_side[g];
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_quo   = low_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

### design/sck_poly.sv
module sck_poly import sck_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [Q_W-1:0]    q,
    input  logic [IN_W-1:0]   h,
    input  sck_side_t         in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  num,
    output logic [H3_W-1:0]   den,
    output sck_side_t         out_side
);

    // stage a: square of q or t, h squared
    logic             a_valid_reg;
    logic [32:0]      a_sq_reg;
    logic [31:0]      a_t_reg;
    logic [47:0]      a_h2_reg;
    logic [IN_W-1:0]  a_h_reg;
    sck_side_t        a_side_reg;
    logic [31:0]      t_next;
    logic [31:0]      x_sel;
    logic [63:0]      sq_prod;

    assign t_next  = 32'h8000_0000 - {1'b0, q};
    assign x_sel   = (in_side.region == REGION_INNER) ? {1'b0, q} : t_next;
    assign sq_prod = x_sel * x_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sq_reg   <= sq_prod[62:30];
        a_t_reg    <= t_next;
        a_h2_reg   <= h * h;
        a_h_reg    <= h;
        a_side_reg <= in_side;
    end

    // stage b: times t, partial products of h cubed
    logic             b_valid_reg;
    logic [32:0]      b_m_reg;
    logic [47:0]      b_hl_reg;
    logic [47:0]      b_hh_reg;
    sck_side_t        b_side_reg;
    logic [64:0]      m_prod;

    assign m_prod = a_sq_reg * a_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_m_reg    <= m_prod[62:30];
        b_hl_reg   <= a_h2_reg[23:0] * a_h_reg;
        b_hh_reg   <= a_h2_reg[47:24] * a_h_reg;
        b_side_reg <= a_side_reg;
    end

    // stage c: polynomial value, h cubed sum
    logic              c_valid_reg;
    logic [POLY_W-1:0] c_p_reg;
    logic [H3_W-1:0]   c_den_reg;
    sck_side_t         c_side_reg;
    logic [34:0]       m3;
    logic [32:0]       d_inner;
    logic [POLY_W-1:0] p_next;

    assign m3      = {2'b0, b_m_reg} + {1'b0, b_m_reg, 1'b0};
    assign d_inner = m3[34:2];

    always_comb
    begin
        if (b_side_reg.region == REGION_INNER)
        begin
            if (d_inner > 33'h0_4000_0000)
            begin
                p_next = '0;
            end
            else
            begin
                p_next = POLY_W'(33'h0_4000_0000 - d_inner);
            end
        end
        else
        begin
            p_next = b_m_reg[POLY_W+1:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_p_reg    <= p_next;
        c_den_reg  <= {24'b0, b_hl_reg} + {b_hh_reg, 24'b0};
        c_side_reg <= b_side_reg;
    end

    // stage d: scale by 1/pi
    logic              d_valid_reg;
    logic [NUM_W-1:0]  d_n_reg;
    logic [H3_W-1:0]   d_den_reg;
    sck_side_t         d_side_reg;
    logic [61:0]       n_prod;

    assign n_prod = c_p_reg * INV_PI_Q32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_n_reg    <= n_prod[NUM_W-1:0];
        d_den_reg  <= c_den_reg;
        d_side_reg <= c_side_reg;
    end

    assign out_valid = d_valid_reg;
    assign num       = d_n_reg;
    assign den       = d_den_reg;
    assign out_side  = d_side_reg;

endmodule
